// ===== sv/ric_pkg.sv =====
// Shared types, constants and codes for the ratio interpolation calibrator.
// Depends on nothing; ric_if, ric_arith, ric_datapath, ric_ctrl and the top use it by scoped names.
package ric_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CFG_W       = 11;
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int RATIO_W     = 49;
	localparam int WIDE_W      = 65;
	localparam int OPND_W      = 33;
	localparam int CNT_W       = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(TABLE_DEPTH);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_LOADED     = 3'd1;
	localparam logic [2:0] ST_BELOW      = 3'd2;
	localparam logic [2:0] ST_ABOVE      = 3'd3;
	localparam logic [2:0] ST_ZERO_DET   = 3'd4;
	localparam logic [2:0] ST_ZERO_WIDTH = 3'd5;

	localparam logic [2:0] A_ZERO = 3'd0;
	localparam logic [2:0] A_NM1  = 3'd1;
	localparam logic [2:0] A_NM2  = 3'd2;
	localparam logic [2:0] A_ONE  = 3'd3;
	localparam logic [2:0] A_I    = 3'd4;
	localparam logic [2:0] A_I1   = 3'd5;
	localparam logic [2:0] A_I2   = 3'd6;

	typedef struct packed {
		logic                     req_type;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] entry_x;
		logic signed [DATA_W-1:0] entry_y;
		logic signed [DATA_W-1:0] peak_position;
		logic signed [DATA_W-1:0] laser_detuning;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rabi_frequency;
		logic [2:0]               status;
	} rsp_t;

	typedef struct packed {
		logic       cap;
		logic       wr;
		logic       div1_start;
		logic       mul_start;
		logic       div2_start;
		logic       take_ratio;
		logic [2:0] addr_sel;
		logic       i_clr;
		logic       i_last;
		logic       i_inc;
		logic       take_l;
		logic       take_r;
		logic       clamp;
		logic       take_y;
		logic       fmul;
		logic       sat;
		logic       set_st;
		logic [2:0] st_code;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic det_zero;
		logic le_x;
		logic ge_x;
		logic gt_x;
		logic i_lt_last;
		logic x_eq;
		logic dy_zero;
		logic busy;
	} sts_t;

endpackage

// ===== sv/ric_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on ric_pkg for the payload types.
interface ric_req_if;
	logic          valid;
	logic          ready;
	ric_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ric_rsp_if;
	logic          valid;
	logic          ready;
	ric_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ric_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ric_pkg::CFG_W-1:0]   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ric_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ric_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/ric_arith.sv =====
// Iterative unit: shift-add multiply (one bit a cycle) and restoring divide.
// Depends on ric_pkg for widths.
module ric_arith (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start_mul,
	input  logic                        start_div,
	input  logic [ric_pkg::WIDE_W-1:0]  w_in,
	input  logic [ric_pkg::OPND_W-1:0]  opnd_in,
	output logic                        busy,
	output logic [ric_pkg::WIDE_W-1:0]  result
);
	localparam int HI_W = ric_pkg::WIDE_W - ric_pkg::DATA_W;

	logic                        busy_q;
	logic                        div_mode_q;
	logic [ric_pkg::CNT_W-1:0]   cnt_q;
	logic [ric_pkg::WIDE_W-1:0]  w_q;
	logic [ric_pkg::OPND_W-1:0]  opnd_q;
	logic [ric_pkg::OPND_W-1:0]  r_q;
	logic [HI_W:0]               msum;
	logic [ric_pkg::OPND_W-1:0]  rs;
	logic                        ge;

	always_comb begin
		msum = {1'b0, w_q[ric_pkg::WIDE_W-1:ric_pkg::DATA_W]}
			+ (w_q[0] ? {1'b0, opnd_q} : '0);
		rs = {r_q[ric_pkg::OPND_W-2:0], w_q[ric_pkg::WIDE_W-1]};
		ge = rs >= opnd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_mode_q <= 1'b0;
			cnt_q      <= '0;
		end else if (start_mul) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b0;
			cnt_q      <= ric_pkg::CNT_W'(ric_pkg::DATA_W);
		end else if (start_div) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b1;
			cnt_q      <= ric_pkg::CNT_W'(ric_pkg::WIDE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ric_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_mul || start_div) begin
			w_q    <= w_in;
			opnd_q <= opnd_in;
			r_q    <= '0;
		end else if (busy_q) begin
			if (div_mode_q) begin
				r_q <= ge ? rs - opnd_q : rs;
				w_q <= {w_q[ric_pkg::WIDE_W-2:0], ge};
			end else begin
				w_q <= {msum, w_q[ric_pkg::DATA_W-1:1]};
			end
		end
	end

	assign busy   = busy_q;
	assign result = w_q;
endmodule

// ===== sv/ric_datapath.sv =====
// Datapath: item and config registers, x/y tables, ratio, search index,
// interpolation and final scaling. Depends on ric_pkg, ric_ram, ric_arith.
module ric_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ric_pkg::cmd_t              cmd,
	output ric_pkg::sts_t              sts,
	input  ric_pkg::req_t              req_in,
	input  logic                       cfg_we,
	input  logic [ric_pkg::CFG_W-1:0]  cfg_data,
	output ric_pkg::rsp_t              rsp_out
);
	localparam int DW = ric_pkg::DATA_W;
	localparam int RW = ric_pkg::RATIO_W;
	localparam int IW = ric_pkg::IDX_W;

	logic [ric_pkg::CFG_W-1:0] cfg_q;
	logic [ric_pkg::CFG_W-1:0] n;
	logic [IW-1:0]             nm1;
	logic [IW-1:0]             nm2;
	ric_pkg::req_t             item_q;
	logic signed [RW-1:0]      ratio_q;
	logic [IW-1:0]             i_q;
	logic [IW-1:0]             raddr;
	logic [DW-1:0]             rd_x;
	logic [DW-1:0]             rd_y;
	logic signed [DW-1:0]      xl_q, xr_q, yl_q, yr_q, y_q;
	logic signed [DW:0]        dy_q;
	logic signed [2*DW-1:0]    prod_q;
	logic signed [DW-1:0]      res_q;
	logic [2:0]                st_q;
	ric_pkg::rsp_t             out_q;

	logic                        ar_busy;
	logic [ric_pkg::WIDE_W-1:0]  ar_res;
	logic [ric_pkg::WIDE_W-1:0]  ar_w;
	logic [ric_pkg::OPND_W-1:0]  ar_opnd;

	logic signed [RW-1:0]  sx_rd, sx_xl, sx_xr;
	logic                  lt_xl, gt_xr;
	logic signed [DW-1:0]  yl_c, yr_c;
	logic signed [DW:0]    dy_c;
	logic [DW:0]           dy_mag;
	logic signed [RW-1:0]  off;
	logic [DW:0]           span;
	logic [DW-1:0]         pk_mag, dt_mag;
	logic [47:0]           q48;
	logic signed [DW+1:0]  y_wide;
	logic [2*DW-1:0]       p_mag;
	logic [2*DW-ric_pkg::FRAC_W-1:0] p_sh;
	logic signed [DW-1:0]  sat_c;

	function automatic logic [DW-1:0] mag32(input logic [DW-1:0] v);
		mag32 = v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	ric_ram #(.WIDTH(DW), .DEPTH(ric_pkg::TABLE_DEPTH)) u_xram (
		.clk(clk), .we(cmd.wr), .waddr(item_q.entry_index), .wdata(item_q.entry_x),
		.raddr(raddr), .rdata(rd_x)
	);

	ric_ram #(.WIDTH(DW), .DEPTH(ric_pkg::TABLE_DEPTH)) u_yram (
		.clk(clk), .we(cmd.wr), .waddr(item_q.entry_index), .wdata(item_q.entry_y),
		.raddr(raddr), .rdata(rd_y)
	);

	ric_arith u_arith (
		.clk(clk), .arst_n(arst_n),
		.start_mul(cmd.mul_start), .start_div(cmd.div1_start || cmd.div2_start),
		.w_in(ar_w), .opnd_in(ar_opnd), .busy(ar_busy), .result(ar_res)
	);

	always_comb begin
		if (cfg_q < ric_pkg::CFG_W'(2)) begin
			n = ric_pkg::CFG_W'(2);
		end else if (cfg_q > ric_pkg::CFG_W'(ric_pkg::TABLE_DEPTH)) begin
			n = ric_pkg::CFG_W'(ric_pkg::TABLE_DEPTH);
		end else begin
			n = cfg_q;
		end
		nm1 = IW'(n - 1'b1);
		nm2 = IW'(n - 2'd2);

		case (cmd.addr_sel)
			ric_pkg::A_ZERO: raddr = '0;
			ric_pkg::A_NM1:  raddr = nm1;
			ric_pkg::A_NM2:  raddr = nm2;
			ric_pkg::A_ONE:  raddr = IW'(1);
			ric_pkg::A_I:    raddr = i_q;
			ric_pkg::A_I1:   raddr = i_q + IW'(1);
			ric_pkg::A_I2:   raddr = i_q + IW'(2);
			default:         raddr = '0;
		endcase

		sx_rd = RW'($signed(rd_x));
		sx_xl = RW'(xl_q);
		sx_xr = RW'(xr_q);

		// clamp to the segment ends, yR first as the ordering matters
		lt_xl = ratio_q < sx_xl;
		gt_xr = ratio_q > sx_xr;
		yr_c  = lt_xl ? yl_q : yr_q;
		yl_c  = gt_xr ? yr_c : yl_q;
		dy_c  = (DW+1)'(yr_c) - (DW+1)'(yl_c);
		dy_mag = dy_q[DW] ? (~dy_q + 1'b1) : dy_q;
		off   = ratio_q - sx_xl;
		span  = (DW+1)'(xr_q) - (DW+1)'(xl_q);

		pk_mag = mag32(item_q.peak_position);
		dt_mag = mag32(item_q.laser_detuning);
		q48    = ar_res[47:0];

		if (cmd.mul_start) begin
			ar_w    = {{(ric_pkg::WIDE_W-DW){1'b0}}, off[DW-1:0]};
			ar_opnd = dy_mag;
		end else if (cmd.div2_start) begin
			ar_w    = ar_res;
			ar_opnd = {1'b0, span[DW-1:0]};
		end else begin
			ar_w    = {{(ric_pkg::WIDE_W-DW-ric_pkg::FRAC_W){1'b0}}, pk_mag,
				{ric_pkg::FRAC_W{1'b0}}};
			ar_opnd = {1'b0, dt_mag};
		end

		y_wide = dy_q[DW] ? ((DW+2)'(yl_q) - $signed({2'b00, ar_res[DW-1:0]}))
			: ((DW+2)'(yl_q) + $signed({2'b00, ar_res[DW-1:0]}));

		p_mag = prod_q[2*DW-1] ? (~prod_q + 1'b1) : prod_q;
		p_sh  = p_mag[2*DW-1:ric_pkg::FRAC_W];
		if (!prod_q[2*DW-1]) begin
			sat_c = (p_sh > (2*DW-ric_pkg::FRAC_W)'(32'h7fff_ffff)) ? 32'sh7fff_ffff
				: $signed(p_sh[DW-1:0]);
		end else begin
			sat_c = (p_sh > (2*DW-ric_pkg::FRAC_W)'(32'h8000_0000)) ? 32'sh8000_0000
				: $signed(~p_sh[DW-1:0] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ric_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= req_in;
		end
		if (cmd.take_ratio) begin
			ratio_q <= (item_q.peak_position[DW-1] ^ item_q.laser_detuning[DW-1])
				? -$signed({1'b0, q48}) : $signed({1'b0, q48});
		end
		if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_last) begin
			i_q <= nm2;
		end else if (cmd.i_inc) begin
			i_q <= i_q + IW'(1);
		end
		if (cmd.take_l) begin
			xl_q <= $signed(rd_x);
			yl_q <= $signed(rd_y);
		end
		if (cmd.take_r) begin
			xr_q <= $signed(rd_x);
			yr_q <= $signed(rd_y);
		end
		if (cmd.clamp) begin
			yl_q <= yl_c;
			dy_q <= dy_c;
		end
		if (cmd.take_y) begin
			y_q <= (dy_q == '0) ? yl_q : y_wide[DW-1:0];
		end
		if (cmd.fmul) begin
			prod_q <= y_q * item_q.laser_detuning;
		end
		if (cmd.set_st) begin
			st_q  <= cmd.st_code;
			res_q <= '0;
		end else if (cmd.sat) begin
			st_q  <= ric_pkg::ST_OK;
			res_q <= sat_c;
		end
		if (cmd.out_load) begin
			out_q.rabi_frequency <= res_q;
			out_q.status         <= st_q;
		end
	end

	always_comb begin
		sts.is_load   = item_q.req_type == ric_pkg::REQ_LOAD;
		sts.det_zero  = item_q.laser_detuning == '0;
		sts.le_x      = ratio_q <= sx_rd;
		sts.ge_x      = ratio_q >= sx_rd;
		sts.gt_x      = ratio_q > sx_rd;
		sts.i_lt_last = i_q < nm2;
		sts.x_eq      = xl_q == xr_q;
		sts.dy_zero   = dy_q == '0;
		sts.busy      = ar_busy;
	end

	assign rsp_out = out_q;
endmodule

// ===== sv/ric_ctrl.sv =====
// Controller: sequences load, ratio divide, range checks, linear search,
// interpolation and scaling. Depends on ric_pkg.
module ric_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ric_pkg::sts_t sts,
	output ric_pkg::cmd_t cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_WDIV1 = 5'd2;
	localparam logic [4:0] S_CX0   = 5'd3;
	localparam logic [4:0] S_CXN   = 5'd4;
	localparam logic [4:0] S_CXN2  = 5'd5;
	localparam logic [4:0] S_SRCH  = 5'd6;
	localparam logic [4:0] S_SEG   = 5'd7;
	localparam logic [4:0] S_SEGL  = 5'd8;
	localparam logic [4:0] S_SEGR  = 5'd9;
	localparam logic [4:0] S_CLAMP = 5'd10;
	localparam logic [4:0] S_CHKDY = 5'd11;
	localparam logic [4:0] S_WMUL  = 5'd12;
	localparam logic [4:0] S_WDIV2 = 5'd13;
	localparam logic [4:0] S_YSET  = 5'd14;
	localparam logic [4:0] S_FMUL  = 5'd15;
	localparam logic [4:0] S_SAT   = 5'd16;
	localparam logic [4:0] S_FIN   = 5'd17;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = state_q == S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_load) begin
					cmd.wr      = 1'b1;
					cmd.set_st  = 1'b1;
					cmd.st_code = ric_pkg::ST_LOADED;
					state_d     = S_FIN;
				end else if (sts.det_zero) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ric_pkg::ST_ZERO_DET;
					state_d     = S_FIN;
				end else begin
					cmd.div1_start = 1'b1;
					state_d        = S_WDIV1;
				end
			end
			S_WDIV1: begin
				if (!sts.busy) begin
					cmd.take_ratio = 1'b1;
					cmd.addr_sel   = ric_pkg::A_ZERO;
					state_d        = S_CX0;
				end
			end
			S_CX0: begin
				if (sts.le_x) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ric_pkg::ST_BELOW;
					state_d     = S_FIN;
				end else begin
					cmd.addr_sel = ric_pkg::A_NM1;
					state_d      = S_CXN;
				end
			end
			S_CXN: begin
				if (sts.ge_x) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ric_pkg::ST_ABOVE;
					state_d     = S_FIN;
				end else begin
					cmd.addr_sel = ric_pkg::A_NM2;
					state_d      = S_CXN2;
				end
			end
			S_CXN2: begin
				if (sts.ge_x) begin
					cmd.i_last = 1'b1;
					state_d    = S_SEG;
				end else begin
					cmd.i_clr    = 1'b1;
					cmd.addr_sel = ric_pkg::A_ONE;
					state_d      = S_SRCH;
				end
			end
			S_SRCH: begin
				// read data is x[i+1]; next address is issued before i moves
				if (sts.i_lt_last && sts.gt_x) begin
					cmd.i_inc    = 1'b1;
					cmd.addr_sel = ric_pkg::A_I2;
				end else begin
					state_d = S_SEG;
				end
			end
			S_SEG: begin
				cmd.addr_sel = ric_pkg::A_I;
				state_d      = S_SEGL;
			end
			S_SEGL: begin
				cmd.take_l   = 1'b1;
				cmd.addr_sel = ric_pkg::A_I1;
				state_d      = S_SEGR;
			end
			S_SEGR: begin
				cmd.take_r = 1'b1;
				state_d    = S_CLAMP;
			end
			S_CLAMP: begin
				if (sts.x_eq) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ric_pkg::ST_ZERO_WIDTH;
					state_d     = S_FIN;
				end else begin
					cmd.clamp = 1'b1;
					state_d   = S_CHKDY;
				end
			end
			S_CHKDY: begin
				if (sts.dy_zero) begin
					state_d = S_YSET;
				end else begin
					cmd.mul_start = 1'b1;
					state_d       = S_WMUL;
				end
			end
			S_WMUL: begin
				if (!sts.busy) begin
					cmd.div2_start = 1'b1;
					state_d        = S_WDIV2;
				end
			end
			S_WDIV2: begin
				if (!sts.busy) begin
					state_d = S_YSET;
				end
			end
			S_YSET: begin
				cmd.take_y = 1'b1;
				state_d    = S_FMUL;
			end
			S_FMUL: begin
				cmd.fmul = 1'b1;
				state_d  = S_SAT;
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== sv/ratio_interpolation_calibrator_unit.sv =====
// Top level of the ratio interpolation calibrator.
// Depends on ric_pkg, ric_if, ric_ctrl, ric_datapath.
//
// Loads (x, y) pairs into a 1024-entry table and answers queries: the ratio
// peak_position / laser_detuning is located in the table by linear search,
// y is interpolated on that segment and scaled by the detuning, saturating to
// 32 bits. One transaction in gives one response out. Items are handled one at
// a time: a query runs the ratio divide (one quotient bit a cycle in the shared
// multiply/divide unit) and the range checks, then the linear search, which
// steps over one table entry a cycle as the x table has one read port, then
// the bit-serial multiply and divide of the interpolation.
// A new request is taken as soon as the previous response sits in the output
// register. entries_in_use must be written only while idle; the block itself
// does not enforce this. Values outside 2..1024 act as the nearest end.
module ratio_interpolation_calibrator_unit (
	input logic         clk,
	input logic         arst_n,
	ric_req_if.sink     req,
	ric_rsp_if.source   rsp,
	ric_cfg_if.sink     cfg
);
	ric_pkg::cmd_t cmd;
	ric_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	ric_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	ric_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.req_in(req.payload),
		.cfg_we(cfg.valid), .cfg_data(cfg.payload),
		.rsp_out(rsp.payload)
	);
endmodule
